// ----- hw/rtl/pac_pkg.sv -----
// pac_pkg: shared types and constants of the polygon area and centroid block
// payload structs, controller command and datapath status structs
// no dependencies
package pac_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 4096;
	localparam int COORD_W = 16;
	localparam int AREA_OUT_W = 45;
	localparam int MIN_AREA_VERTICES = 3;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = 16'sh7fff;
	localparam coord_t COORD_MIN = 16'sh8000;

	typedef struct packed {
		coord_t vertex_x;
		coord_t vertex_y;
		logic   last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [AREA_OUT_W-1:0] twice_area;
		coord_t                       centroid_x;
		coord_t                       centroid_y;
		logic                         used_vertex_mean;
	} result_t;

	typedef struct packed {
		logic take;
		logic close;
		logic latch_area;
		logic latch_den;
		logic div_start;
		logic sel_y;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic div_busy;
		logic div_done;
		logic out_full;
	} dp_sts_t;

endpackage

// ----- hw/rtl/pac_div.sv -----
// pac_div: serial signed divider, one quotient bit per cycle, saturated to a coordinate
// depends on pac_pkg
module pac_div #(
	parameter int NW = 62,
	parameter int DW = 46
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	input  logic                 den_neg,
	output logic                 busy,
	output logic                 done,
	output pac_pkg::coord_t      quot
);

	localparam int QB = pac_pkg::COORD_W - 1;
	localparam int SW = DW + QB;
	localparam int CW = ((NW > SW) ? NW : SW) + 1;
	localparam int STEPS = QB + 1;
	localparam int ST_W = $clog2(STEPS);

	logic [NW-1:0]   rem_q;
	logic [SW-1:0]   dsh_q;
	logic [QB-1:0]   quo_q;
	logic            ovf_q;
	logic            neg_q;
	logic [ST_W-1:0] step_q;
	logic            busy_q;
	logic            done_q;

	logic [CW-1:0] rem_ext;
	logic [CW-1:0] dsh_ext;
	logic [CW-1:0] diff;
	logic          ge;
	logic [pac_pkg::COORD_W-1:0] mag;

	assign rem_ext = CW'(rem_q);
	assign dsh_ext = CW'(dsh_q);
	assign diff = rem_ext - dsh_ext;
	assign ge = (rem_ext >= dsh_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= ST_W'(QB);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NW-1] ? NW'(-num) : NW'(num);
			dsh_q <= {den, {QB{1'b0}}};
			neg_q <= num[NW-1] ^ den_neg;
			ovf_q <= 1'b0;
			quo_q <= '0;
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			if (step_q == ST_W'(QB)) begin
				// top probe: quotient of 2^15 or more saturates
				ovf_q <= ge;
			end else begin
				quo_q <= {quo_q[QB-2:0], ge};
				if (ge) begin
					rem_q <= diff[NW-1:0];
				end
			end
		end
	end

	assign mag = {1'b0, quo_q};

	always_comb begin
		if (ovf_q) begin
			quot = neg_q ? pac_pkg::COORD_MIN : pac_pkg::COORD_MAX;
		end else if (neg_q) begin
			quot = pac_pkg::coord_t'(-mag);
		end else begin
			quot = pac_pkg::coord_t'(mag);
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ----- hw/rtl/pac_dp.sv -----
// pac_dp: vertex registers, edge cross-product pipeline, accumulators, result register
// depends on pac_pkg and pac_div
module pac_dp #(
	parameter int unsigned MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pac_pkg::vertex_t   vertex,
	input  pac_pkg::ctrl_cmd_t cmd,
	input  logic               result_ready,
	output pac_pkg::dp_sts_t   sts,
	output pac_pkg::result_t   result,
	output logic               result_valid
);

	localparam int LOG_N = $clog2(MAX_VERTICES);
	localparam int CNT_W = LOG_N + 1;
	localparam int SUM_W = LOG_N + pac_pkg::COORD_W;
	localparam int AREA_W = LOG_N + 2 * pac_pkg::COORD_W + 1;
	localparam int MOM_W = (LOG_N + 50 > 64) ? 64 : LOG_N + 50;
	localparam int DEN_W = AREA_W + 1;
	localparam int P_W = 2 * pac_pkg::COORD_W;
	localparam int C_W = P_W + 1;
	localparam int S_W = pac_pkg::COORD_W + 1;
	localparam int M_W = S_W + C_W;

	pac_pkg::coord_t first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                     have_first_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  sum_x_q, sum_y_q;
	logic signed [AREA_W-1:0] area_q;
	logic signed [MOM_W-1:0]  mom_x_q, mom_y_q;

	logic v_s1, v_s2, v_s3;
	logic signed [P_W-1:0] p1_s1, p2_s1;
	logic signed [S_W-1:0] sx_s1, sy_s1, sx_s2, sy_s2;
	logic signed [C_W-1:0] c_s2, c_s3;
	logic signed [M_W-1:0] mx_s3, my_s3;

	logic signed [AREA_W-1:0] area_fin_q;
	logic                     use_mean_q;
	logic [AREA_W-1:0]        abs_area_q;
	logic [DEN_W-1:0]         den_q;
	pac_pkg::coord_t          cx_q, cy_q;

	logic                     can_add;
	logic                     edge_go;
	pac_pkg::coord_t          eb_x, eb_y;
	logic signed [AREA_W-1:0] area_fin;
	logic signed [MOM_W-1:0]  div_num;
	logic                     div_busy, div_done;
	pac_pkg::coord_t          div_quot;

	assign can_add = (count_q < CNT_W'(MAX_VERTICES));
	assign edge_go = (cmd.take && have_first_q && can_add) || cmd.close;
	assign eb_x = cmd.close ? first_x_q : vertex.vertex_x;
	assign eb_y = cmd.close ? first_y_q : vertex.vertex_y;
	assign area_fin = (count_q < CNT_W'(pac_pkg::MIN_AREA_VERTICES)) ? '0 : area_q;

	// control and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
			count_q <= '0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			area_q <= '0;
			mom_x_q <= '0;
			mom_y_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_s1 <= edge_go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.take) begin
				if (!have_first_q) begin
					have_first_q <= 1'b1;
					count_q <= CNT_W'(1);
					sum_x_q <= SUM_W'(vertex.vertex_x);
					sum_y_q <= SUM_W'(vertex.vertex_y);
				end else if (can_add) begin
					count_q <= count_q + 1'b1;
					sum_x_q <= sum_x_q + SUM_W'(vertex.vertex_x);
					sum_y_q <= sum_y_q + SUM_W'(vertex.vertex_y);
				end
			end
			if (v_s3) begin
				area_q <= area_q + AREA_W'(c_s3);
				mom_x_q <= mom_x_q + MOM_W'(mx_s3);
				mom_y_q <= mom_y_q + MOM_W'(my_s3);
			end
			if (cmd.out_load) begin
				have_first_q <= 1'b0;
				count_q <= '0;
				area_q <= '0;
				mom_x_q <= '0;
				mom_y_q <= '0;
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// vertex registers, edge pipeline and result payload
	always_ff @(posedge clk) begin
		if (cmd.take && (!have_first_q || can_add)) begin
			prev_x_q <= vertex.vertex_x;
			prev_y_q <= vertex.vertex_y;
		end
		if (cmd.take && !have_first_q) begin
			first_x_q <= vertex.vertex_x;
			first_y_q <= vertex.vertex_y;
		end
		p1_s1 <= P_W'(prev_x_q) * P_W'(eb_y);
		p2_s1 <= P_W'(eb_x) * P_W'(prev_y_q);
		sx_s1 <= S_W'(prev_x_q) + S_W'(eb_x);
		sy_s1 <= S_W'(prev_y_q) + S_W'(eb_y);
		c_s2 <= C_W'(p1_s1) - C_W'(p2_s1);
		sx_s2 <= sx_s1;
		sy_s2 <= sy_s1;
		mx_s3 <= M_W'(sx_s2) * M_W'(c_s2);
		my_s3 <= M_W'(sy_s2) * M_W'(c_s2);
		c_s3 <= c_s2;
		if (cmd.latch_area) begin
			area_fin_q <= area_fin;
			use_mean_q <= (area_fin == '0);
			abs_area_q <= area_fin[AREA_W-1] ? AREA_W'(-area_fin) : AREA_W'(area_fin);
		end
		if (cmd.latch_den) begin
			den_q <= use_mean_q ? DEN_W'(count_q) : DEN_W'(abs_area_q) + {abs_area_q, 1'b0};
		end
		if (div_done) begin
			if (cmd.sel_y) begin
				cy_q <= div_quot;
			end else begin
				cx_q <= div_quot;
			end
		end
		if (cmd.out_load) begin
			result.twice_area <= pac_pkg::AREA_OUT_W'(area_fin_q);
			result.centroid_x <= cx_q;
			result.centroid_y <= cy_q;
			result.used_vertex_mean <= use_mean_q;
		end
	end

	always_comb begin
		if (use_mean_q) begin
			div_num = cmd.sel_y ? MOM_W'(sum_y_q) : MOM_W'(sum_x_q);
		end else begin
			div_num = cmd.sel_y ? mom_y_q : mom_x_q;
		end
	end

	pac_div #(
		.NW(MOM_W),
		.DW(DEN_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(div_num),
		.den(den_q),
		.den_neg(area_fin_q[AREA_W-1]),
		.busy(div_busy),
		.done(div_done),
		.quot(div_quot)
	);

	assign sts.pipe_busy = v_s1 || v_s2 || v_s3;
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.out_full = result_valid;

endmodule

// ----- hw/rtl/pac_ctrl.sv -----
// pac_ctrl: sequencer for vertex intake, polygon close, pipeline drain and the two divisions
// depends on pac_pkg
module pac_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vertex_valid,
	input  logic               last_vertex,
	input  logic               result_ready,
	input  pac_pkg::dp_sts_t   sts,
	output logic               vertex_ready,
	output pac_pkg::ctrl_cmd_t cmd
);

	localparam logic [3:0] S_RUN   = 4'd0;
	localparam logic [3:0] S_CLOSE = 4'd1;
	localparam logic [3:0] S_DRAIN = 4'd2;
	localparam logic [3:0] S_AREA  = 4'd3;
	localparam logic [3:0] S_DEN   = 4'd4;
	localparam logic [3:0] S_DIVX  = 4'd5;
	localparam logic [3:0] S_WAITX = 4'd6;
	localparam logic [3:0] S_DIVY  = 4'd7;
	localparam logic [3:0] S_WAITY = 4'd8;
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_free;

	assign out_free = !sts.out_full || result_ready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		vertex_ready = 1'b0;
		case (state_q)
			S_RUN: begin
				vertex_ready = 1'b1;
				cmd.take = vertex_valid;
				if (vertex_valid && last_vertex) begin
					state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = S_AREA;
				end
			end
			S_AREA: begin
				cmd.latch_area = 1'b1;
				state_d = S_DEN;
			end
			S_DEN: begin
				cmd.latch_den = 1'b1;
				state_d = S_DIVX;
			end
			S_DIVX: begin
				cmd.div_start = 1'b1;
				state_d = S_WAITX;
			end
			S_WAITX: begin
				if (sts.div_done) begin
					state_d = S_DIVY;
				end
			end
			S_DIVY: begin
				cmd.sel_y = 1'b1;
				cmd.div_start = 1'b1;
				state_d = S_WAITY;
			end
			S_WAITY: begin
				cmd.sel_y = 1'b1;
				if (sts.div_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_RUN;
				end
			end
			default: begin
				state_d = S_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/polygon_area_centroid.sv -----
// polygon_area_centroid: top level, shoelace area and area centroid of a streamed polygon
// depends on pac_pkg, pac_ctrl, pac_dp (which holds pac_div)
//
// channel  | dir | handshake                   | payload
// vertex   | in  | vertex_valid / vertex_ready | pac_pkg::vertex_t
// result   | out | result_valid / result_ready | pac_pkg::result_t
//
// vertices are taken one per cycle; each edge goes through a three-stage multiply pipeline
// a vertex marked last is followed by closing edge, drain, two 16-step divisions
// the 16-step serial divider sets the per-polygon overhead; no vertex is taken meanwhile
// result sits in an output register, so the next polygon starts while it waits
// reset clears all accumulators and the sequencer; no clearing pass is needed
module polygon_area_centroid #(
	parameter int unsigned MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vertex_valid,
	output logic             vertex_ready,
	input  pac_pkg::vertex_t vertex,
	output logic             result_valid,
	input  logic             result_ready,
	output pac_pkg::result_t result
);

	pac_pkg::ctrl_cmd_t cmd;
	pac_pkg::dp_sts_t   sts;

	pac_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.vertex_valid(vertex_valid),
		.last_vertex(vertex.last_vertex),
		.result_ready(result_ready),
		.sts(sts),
		.vertex_ready(vertex_ready),
		.cmd(cmd)
	);

	pac_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.vertex(vertex),
		.cmd(cmd),
		.result_ready(result_ready),
		.sts(sts),
		.result(result),
		.result_valid(result_valid)
	);

	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.pipe_busy && !sts.div_busy && (!result_valid || result_ready))
		else $error("result loaded while work pending or output occupied");

	a_no_intake_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> !vertex_ready)
		else $error("vertex intake open during division");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy && !sts.pipe_busy)
		else $error("division started while divider or pipeline busy");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result_valid)
		else $error("result register not filled after load");

endmodule

// ----- tb/pac_checker.sv -----
// pac_checker: watches the vertex and result channels of polygon_area_centroid,
// predicts each polygon's area and centroid, and compares every result item
// depends on pac_pkg
module pac_checker import pac_pkg::*; #(
	parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    vertex_valid,
	input  logic    vertex_ready,
	input  vertex_t vertex,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      mismatches,
	output int      awaiting
);

	int          first_x, first_y, prev_x, prev_y;
	longint      area_acc, mom_x, mom_y, sum_x, sum_y;
	int unsigned n_kept;
	bit          have_first;
	result_t     centroid_q[$];
	int          bad = 0;
	int          awaiting_r = 0;

	assign mismatches = bad;
	assign awaiting   = awaiting_r;

	function automatic void clear_polygon();
		first_x    = 0;
		first_y    = 0;
		prev_x     = 0;
		prev_y     = 0;
		area_acc   = 0;
		mom_x      = 0;
		mom_y      = 0;
		sum_x      = 0;
		sum_y      = 0;
		n_kept     = 0;
		have_first = 1'b0;
	endfunction

	function automatic void add_edge(int ax, int ay, int bx, int by);
		longint c;
		c = longint'(ax) * by - longint'(bx) * ay;
		area_acc += c;
		mom_x    += (longint'(ax) + bx) * c;
		mom_y    += (longint'(ay) + by) * c;
	endfunction

	function automatic coord_t clamp_coord(longint v);
		if (v > longint'(COORD_MAX))
			return COORD_MAX;
		if (v < longint'(COORD_MIN))
			return COORD_MIN;
		return coord_t'(v);
	endfunction

	// returns 1 when the vertex closes a polygon and r holds its result
	function automatic bit shoelace_step(vertex_t v, output result_t r);
		int     x, y;
		longint area, den, cnt;
		x = int'($signed(v.vertex_x));
		y = int'($signed(v.vertex_y));
		r = '0;
		if (!have_first) begin
			first_x    = x;
			first_y    = y;
			prev_x     = x;
			prev_y     = y;
			sum_x      = x;
			sum_y      = y;
			n_kept     = 1;
			have_first = 1'b1;
		end else if (n_kept < MAX_VERTICES) begin
			add_edge(prev_x, prev_y, x, y);
			prev_x = x;
			prev_y = y;
			sum_x += x;
			sum_y += y;
			n_kept++;
		end
		if (!v.last_vertex)
			return 1'b0;
		add_edge(prev_x, prev_y, first_x, first_y);
		area = (n_kept < MIN_AREA_VERTICES) ? 64'sd0 : area_acc;
		if (area != 0) begin
			den                = 3 * area;
			r.centroid_x       = clamp_coord(mom_x / den);
			r.centroid_y       = clamp_coord(mom_y / den);
			r.used_vertex_mean = 1'b0;
		end else begin
			cnt                = (n_kept < 1) ? 64'sd1 : longint'(n_kept);
			r.centroid_x       = clamp_coord(sum_x / cnt);
			r.centroid_y       = clamp_coord(sum_y / cnt);
			r.used_vertex_mean = 1'b1;
		end
		r.twice_area = area[AREA_OUT_W-1:0];
		clear_polygon();
		return 1'b1;
	endfunction

	initial clear_polygon();

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want, got;
		if (!arst_n) begin
			clear_polygon();
			centroid_q.delete();
		end else begin
			if (vertex_valid && vertex_ready && shoelace_step(vertex, want))
				centroid_q = {centroid_q, want};
			if (result_valid && result_ready) begin
				got = result;
				if (centroid_q.size() == 0) begin
					if (bad < 10)
						$display("unexpected result item: area %0d cx %0d cy %0d mean %0b",
							$signed(got.twice_area), $signed(got.centroid_x),
							$signed(got.centroid_y), got.used_vertex_mean);
					bad++;
				end else begin
					want = centroid_q.pop_front();
					if (got.twice_area !== want.twice_area
							|| got.centroid_x !== want.centroid_x
							|| got.centroid_y !== want.centroid_y
							|| got.used_vertex_mean !== want.used_vertex_mean) begin
						if (bad < 10)
							$display({"mismatch at %0t: expected area %0d cx %0d cy %0d mean %0b,",
								" got area %0d cx %0d cy %0d mean %0b"}, $realtime,
								$signed(want.twice_area), $signed(want.centroid_x),
								$signed(want.centroid_y), want.used_vertex_mean,
								$signed(got.twice_area), $signed(got.centroid_x),
								$signed(got.centroid_y), got.used_vertex_mean);
						bad++;
					end
				end
			end
		end
		awaiting_r = centroid_q.size();
	end

endmodule

// ----- tb/polygon_area_centroid_tb.sv -----
// polygon_area_centroid_tb: drives polygons into polygon_area_centroid under several
// idle and stall patterns; pac_checker predicts and compares the results
// depends on pac_pkg, pac_checker and the block's rtl
module polygon_area_centroid_tb;
	import pac_pkg::*;

	localparam int unsigned MAXV = MAX_VERTICES_DEF;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    vertex_valid;
	logic    vertex_ready;
	vertex_t vertex;
	logic    result_valid;
	logic    result_ready;
	result_t result;
	int      mismatches;
	int      awaiting;

	int      send_idle  = 0;
	int      recv_stall = 0;
	bit      hold_req   = 1'b0;
	int      sent       = 0;
	vertex_t poly[$];

	polygon_area_centroid #(.MAX_VERTICES(MAXV)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.vertex       (vertex),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	pac_checker #(.MAX_VERTICES(MAXV)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.vertex       (vertex),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.mismatches   (mismatches),
		.awaiting     (awaiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// result side, with one long hold-off at the start of the first random phase
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req     = 1'b0;
				result_ready = 1'b0;
				repeat (300) @(negedge clk);
			end
			result_ready = ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send_item(input vertex_t v);
		while ($urandom_range(99) < send_idle) begin
			vertex_valid = 1'b0;
			vertex       = vertex_t'($urandom);
			@(negedge clk);
		end
		vertex_valid = 1'b1;
		vertex       = v;
		do @(posedge clk); while (!vertex_ready);
		@(negedge clk);
	endtask

	task automatic add_pt(input int x, input int y);
		vertex_t v;
		v.vertex_x    = coord_t'(x);
		v.vertex_y    = coord_t'(y);
		v.last_vertex = 1'b0;
		poly = {poly, v};
	endtask

	task automatic send_polygon();
		poly[poly.size()-1].last_vertex = 1'b1;
		foreach (poly[i])
			send_item(poly[i]);
		sent += poly.size();
		poly.delete();
	endtask

	task automatic random_polygon();
		int n, k, kind, bx, by, dx, dy, x0, x1, y0, y1;
		kind = $urandom_range(99);
		if (kind < 50) begin
			n = $urandom_range(3, 10);
			repeat (n) add_pt($urandom, $urandom);
		end else if (kind < 62) begin
			n = $urandom_range(1, 2);
			repeat (n) add_pt($urandom, $urandom);
		end else if (kind < 72) begin
			// points on one line, zero area
			bx = int'($urandom_range(20000)) - 10000;
			by = int'($urandom_range(20000)) - 10000;
			dx = int'($urandom_range(40)) - 20;
			dy = int'($urandom_range(40)) - 20;
			n  = $urandom_range(3, 8);
			repeat (n) begin
				k = $urandom_range(7);
				add_pt(bx + k * dx, by + k * dy);
			end
		end else if (kind < 86) begin
			n = $urandom_range(3, 8);
			repeat (n) add_pt(int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8);
		end else begin
			x0 = int'($signed(coord_t'($urandom)));
			x1 = int'($signed(coord_t'($urandom)));
			y0 = int'($signed(coord_t'($urandom)));
			y1 = int'($signed(coord_t'($urandom)));
			add_pt(x0, y0);
			add_pt(x1, y0);
			add_pt(x1, y1);
			add_pt(x0, y1);
		end
		send_polygon();
	endtask

	initial begin : stimulus
		int idle_tab[4];
		int stall_tab[4];
		idle_tab     = '{0, 48, 0, 7};
		stall_tab    = '{0, 0, 48, 7};
		arst_n       = 1'b0;
		vertex_valid = 1'b0;
		vertex       = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single-vertex polygons at both corners
		add_pt(-32768, -32768);
		send_polygon();
		add_pt(32767, 32767);
		send_polygon();
		// two vertices, mean of opposite extremes
		add_pt(-32768, 32767);
		add_pt(32767, -32768);
		send_polygon();
		// full-range square, counter-clockwise
		add_pt(-32768, -32768);
		add_pt(32767, -32768);
		add_pt(32767, 32767);
		add_pt(-32768, 32767);
		send_polygon();
		// figure-eight with nearly cancelling loops, centroid saturates low
		add_pt(-10000, 0);
		add_pt(-10000, 100);
		add_pt(-30000, 100);
		add_pt(-30000, 0);
		add_pt(-10000, 0);
		add_pt(10000, 0);
		add_pt(10000, 99);
		add_pt(30000, 99);
		add_pt(30000, 0);
		send_polygon();
		// same with the clockwise loop larger, saturates high
		add_pt(-10000, 0);
		add_pt(-10000, 100);
		add_pt(-30000, 100);
		add_pt(-30000, 0);
		add_pt(-10000, 0);
		add_pt(10000, 0);
		add_pt(10000, 101);
		add_pt(30000, 101);
		add_pt(30000, 0);
		send_polygon();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle  = idle_tab[ph];
			recv_stall = stall_tab[ph];
			sent       = 0;
			if (ph == 0)
				hold_req = 1'b1;
			while (sent < 225)
				random_polygon();
		end

		vertex_valid = 1'b0;
		while (awaiting != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
